/* design/rups_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rups_pkg
// shared types, codes and limits for the rectangle update / prefix sum block
// ---------------------------------------------------------------------------
package rups_pkg;

   localparam int DefMaxRows = 32;
   localparam int DefMaxCols = 32;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_COORD = 2'd1;
   localparam logic [1:0] ST_PHASE = 2'd2;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_LOAD  = 3'd1;
   localparam logic [2:0] OP_RADD  = 3'd2;
   localparam logic [2:0] OP_BUILD = 3'd3;
   localparam logic [2:0] OP_QUERY = 3'd4;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // datapath accumulator selection
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CORNER_RD,
      S_CORNER_WAIT,
      S_CORNER_WR,
      S_BLD_RD,
      S_BLD_WAIT,
      S_BLD_WR,
      S_QRY_RD,
      S_QRY_WAIT,
      S_RESP
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        mem_rd;
      logic        mem_wr;
      logic [9:0]  rd_row;
      logic [9:0]  rd_col;
      logic [9:0]  wr_row;
      logic [9:0]  wr_col;
      logic        wr_zero;
      acc_op_type  acc_op;
      logic        acc_neg_amt;
      logic        acc_use_amt;
   } cmd_type;

endpackage
`default_nettype wire

/* design/rups_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rups_datapath
// grid memory with registered read and a 64-bit accumulator
// ---------------------------------------------------------------------------
module rups_datapath
   import rups_pkg::*;
#(
   parameter int MAX_ROWS = DefMaxRows,
   parameter int MAX_COLS = DefMaxCols
) (
   input  wire logic         clock,
   input  wire cmd_type      cmd,
   input  wire logic [31:0]  amount,
   output logic [63:0]       acc
);
   localparam int Depth = MAX_ROWS * MAX_COLS;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   logic [63:0] mem [Depth];
   logic [63:0] rd_data_ff;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] amt_ext, opnd;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [19:0] rd_lin, wr_lin;

   assign rd_lin = 20'(cmd.rd_row) * 20'(MAX_COLS) + 20'(cmd.rd_col);
   assign wr_lin = 20'(cmd.wr_row) * 20'(MAX_COLS) + 20'(cmd.wr_col);
   assign rd_addr = rd_lin[AW-1:0];
   assign wr_addr = wr_lin[AW-1:0];

   // memory port
   always_ff @(posedge clock) begin
      if (cmd.mem_wr)
         mem[wr_addr] <= cmd.wr_zero ? 64'd0 : acc_ff;
      if (cmd.mem_rd)
         rd_data_ff <= mem[rd_addr];
   end

   assign amt_ext = {{32{amount[31]}}, amount};
   assign opnd = cmd.acc_use_amt ? (cmd.acc_neg_amt ? 64'd0 - amt_ext : amt_ext)
                                 : rd_data_ff;

   // accumulator
   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = opnd;
         ACC_ADD:  acc_in = acc_ff + opnd;
         ACC_SUB:  acc_in = acc_ff - opnd;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;
endmodule
`default_nettype wire

/* design/rups_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rups_ctrl
// sequencer for clear, corner updates, prefix passes and queries
// ---------------------------------------------------------------------------
module rups_ctrl
   import rups_pkg::*;
#(
   parameter int MAX_ROWS = DefMaxRows,
   parameter int MAX_COLS = DefMaxCols
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_opcode,
   input  wire logic [4:0]   req_row_first,
   input  wire logic [4:0]   req_col_first,
   input  wire logic [4:0]   req_row_last,
   input  wire logic [4:0]   req_col_last,
   input  wire logic [5:0]   rows_cfg,
   input  wire logic [5:0]   cols_cfg,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_status,
   output logic              rsp_is_sum,
   output cmd_type           cmd
);
   state_type state_ff, state_in;
   logic [10:0] nr, nc;
   logic [9:0]  r1_ff, c1_ff, r2_ff, c2_ff;
   logic [9:0]  r1_in, c1_in, r2_in, c2_in;
   logic [9:0]  i_ff, j_ff, i_in, j_in;
   logic [1:0]  k_ff, k_in;
   logic        pass_ff, pass_in;
   logic        built_ff, built_in;
   logic [1:0]  st_ff, st_in;
   logic        sum_ff, sum_in;
   logic        rv_ff, rv_in;
   logic        init_ff, init_in;
   logic        acc;
   logic        bad;
   logic        in_rng;
   logic [9:0]  cr, cc;
   logic [9:0]  tr, tc;
   logic        tv;
   logic        last_cell;
   logic        qtv_ff;

   // effective counts
   always_comb begin
      nr = (rows_cfg == 6'd0) ? 11'd1 :
           (32'(rows_cfg) > MAX_ROWS) ? 11'(MAX_ROWS) : 11'(rows_cfg);
      nc = (cols_cfg == 6'd0) ? 11'd1 :
           (32'(cols_cfg) > MAX_COLS) ? 11'(MAX_COLS) : 11'(cols_cfg);
   end

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign acc = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_is_sum = sum_ff;

   // corner k target: 0 (r1,c1) 1 (r2+1,c1) 2 (r1,c2+1) 3 (r2+1,c2+1)
   always_comb begin
      cr = k_ff[0] ? r2_ff + 10'd1 : r1_ff;
      cc = k_ff[1] ? c2_ff + 10'd1 : c1_ff;
      in_rng = (32'(cr) < MAX_ROWS) && (32'(cc) < MAX_COLS);
   end

   // query term k: 0 (r2,c2) + , 1 (r1-1,c2) - , 2 (r2,c1-1) - , 3 (r1-1,c1-1) +
   always_comb begin
      tr = k_ff[0] ? r1_ff - 10'd1 : r2_ff;
      tc = k_ff[1] ? c1_ff - 10'd1 : c2_ff;
      tv = !(k_ff[0] && r1_ff == 10'd0) && !(k_ff[1] && c1_ff == 10'd0);
   end

   assign last_cell = ({1'b0, i_ff} == nr - 11'd1) && ({1'b0, j_ff} == nc - 11'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      r1_in = r1_ff; c1_in = c1_ff; r2_in = r2_ff; c2_in = c2_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; pass_in = pass_ff;
      built_in = built_ff; st_in = st_ff; sum_in = sum_ff; rv_in = rv_ff;
      init_in = init_ff;
      bad = 1'b0;
      if (rv_ff && !rsp_stall)
         rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               r1_in = 10'(req_row_first); c1_in = 10'(req_col_first);
               r2_in = 10'(req_row_last);  c2_in = 10'(req_col_last);
               st_in = ST_OK; sum_in = 1'b0; k_in = 2'd0;
               i_in = 10'd0; j_in = 10'd0; pass_in = 1'b0;
               case (req_opcode)
                  OP_CLEAR: begin
                     built_in = 1'b0;
                     state_in = S_CLEAR;
                  end
                  OP_LOAD: begin
                     r2_in = 10'(req_row_first); c2_in = 10'(req_col_first);
                     bad = (11'(req_row_first) >= nr) || (11'(req_col_first) >= nc);
                     if (built_ff) begin
                        st_in = ST_PHASE; state_in = S_RESP;
                     end else if (bad) begin
                        st_in = ST_COORD; state_in = S_RESP;
                     end else state_in = S_CORNER_RD;
                  end
                  OP_RADD, OP_QUERY: begin
                     bad = (req_row_first > req_row_last) ||
                           (req_col_first > req_col_last) ||
                           (11'(req_row_last) >= nr) || (11'(req_col_last) >= nc);
                     if ((req_opcode == OP_RADD) == built_ff) begin
                        st_in = ST_PHASE; state_in = S_RESP;
                     end else if (bad) begin
                        st_in = ST_COORD; state_in = S_RESP;
                     end else if (req_opcode == OP_RADD) state_in = S_CORNER_RD;
                     else begin
                        sum_in = 1'b1; state_in = S_QRY_RD;
                     end
                  end
                  OP_BUILD: begin
                     if (built_ff) begin
                        st_in = ST_PHASE; state_in = S_RESP;
                     end else state_in = S_BLD_RD;
                  end
                  default: begin
                     st_in = ST_PHASE; state_in = S_RESP;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            // walk every grid cell, row by row
            if (j_ff == 10'(MAX_COLS - 1)) begin
               j_in = 10'd0; i_in = i_ff + 10'd1;
            end else j_in = j_ff + 10'd1;
            if (i_ff == 10'(MAX_ROWS - 1) && j_ff == 10'(MAX_COLS - 1)) begin
               i_in = 10'd0; j_in = 10'd0;
               // the pass after reset answers nothing
               if (init_ff) begin
                  init_in = 1'b0; state_in = S_IDLE;
               end else state_in = S_RESP;
            end
         end
         S_CORNER_RD: begin
            if (in_rng) state_in = S_CORNER_WAIT;
            else if (k_ff == 2'd3) state_in = S_RESP;
            else k_in = k_ff + 2'd1;
         end
         S_CORNER_WAIT: state_in = S_CORNER_WR;
         S_CORNER_WR: begin
            if (k_ff == 2'd3) state_in = S_RESP;
            else begin
               k_in = k_ff + 2'd1; state_in = S_CORNER_RD;
            end
         end
         S_BLD_RD: begin
            // k counts the four reads of one cell update
            if (k_ff == 2'd3) state_in = S_BLD_WAIT;
            else k_in = k_ff + 2'd1;
         end
         S_BLD_WAIT: state_in = S_BLD_WR;
         S_BLD_WR: begin
            k_in = 2'd0;
            state_in = S_BLD_RD;
            if ({1'b0, j_ff} == nc - 11'd1) begin
               j_in = 10'd0; i_in = i_ff + 10'd1;
            end else j_in = j_ff + 10'd1;
            if (last_cell) begin
               i_in = 10'd0; j_in = 10'd0;
               if (pass_ff) begin
                  built_in = 1'b1; state_in = S_RESP;
               end else pass_in = 1'b1;
            end
         end
         S_QRY_RD: begin
            if (k_ff == 2'd3) state_in = S_QRY_WAIT;
            else k_in = k_ff + 2'd1;
         end
         S_QRY_WAIT: state_in = S_RESP;
         S_RESP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      cmd.acc_op = ACC_HOLD;
      case (state_ff)
         S_CLEAR: begin
            cmd.mem_wr = 1'b1; cmd.wr_zero = 1'b1;
            cmd.wr_row = i_ff;
            cmd.wr_col = j_ff;
         end
         S_CORNER_RD: begin
            // read the corner cell and preload the signed amount
            cmd.rd_row = cr; cmd.rd_col = cc; cmd.mem_rd = in_rng;
            cmd.acc_op = ACC_LOAD; cmd.acc_use_amt = 1'b1;
            cmd.acc_neg_amt = k_ff[0] ^ k_ff[1];
         end
         S_CORNER_WAIT: begin
            cmd.acc_op = ACC_ADD;
         end
         S_CORNER_WR: begin
            cmd.mem_wr = 1'b1; cmd.wr_row = cr; cmd.wr_col = cc;
         end
         S_BLD_RD: begin
            // reads: k0 (i,j) k1 (i-1,j) k2 (i,j-1) k3 (i-1,j-1)
            cmd.mem_rd = 1'b1;
            cmd.rd_row = k_ff[0] ? i_ff - 10'd1 : i_ff;
            cmd.rd_col = k_ff[1] ? j_ff - 10'd1 : j_ff;
         end
         S_BLD_WAIT: begin
            // last read lands now: term (i-1,j-1), subtracted
            cmd.acc_op = (i_ff != 10'd0 && j_ff != 10'd0) ? ACC_SUB : ACC_HOLD;
         end
         S_BLD_WR: begin
            cmd.mem_wr = 1'b1; cmd.wr_row = i_ff; cmd.wr_col = j_ff;
         end
         S_QRY_RD: begin
            cmd.mem_rd = 1'b1; cmd.rd_row = tr; cmd.rd_col = tc;
         end
         S_QRY_WAIT: begin
            cmd.acc_op = ACC_ADD;
         end
         default: ;
      endcase
      // accumulate the read issued in the previous cycle
      if (state_ff == S_CORNER_WAIT) cmd.acc_op = ACC_ADD;
      if (state_ff == S_BLD_RD && k_ff != 2'd0) begin
         case (k_ff)
            2'd1: cmd.acc_op = ACC_LOAD;
            2'd2: cmd.acc_op = (i_ff != 10'd0) ? ACC_ADD : ACC_HOLD;
            default: cmd.acc_op = (j_ff != 10'd0) ? ACC_ADD : ACC_HOLD;
         endcase
      end
      if (state_ff == S_QRY_RD && k_ff != 2'd0) begin
         case (k_ff)
            2'd1: cmd.acc_op = ACC_LOAD;
            default: cmd.acc_op = qtv_ff ? ACC_SUB : ACC_HOLD;
         endcase
      end
      if (state_ff == S_QRY_WAIT)
         cmd.acc_op = qtv_ff ? ACC_ADD : ACC_HOLD;
   end

   // validity of the previous query term
   always_ff @(posedge clock) begin
      qtv_ff <= tv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         built_ff <= 1'b0;
         rv_ff <= 1'b0;
         init_ff <= 1'b1;
         i_ff <= 10'd0;
         j_ff <= 10'd0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         rv_ff <= rv_in;
         init_ff <= init_in;
         i_ff <= i_in;
         j_ff <= j_in;
      end
      r1_ff <= r1_in; c1_ff <= c1_in; r2_ff <= r2_in; c2_ff <= c2_in;
      k_ff <= k_in; pass_ff <= pass_in;
      st_ff <= st_in; sum_ff <= sum_in;
   end
endmodule
`default_nettype wire

/* design/rect_update_prefix_sum_query.sv */
`default_nettype none
// clear walks all MAX_ROWS*MAX_COLS cells; build walks the rows*cols cells in use,
// in two passes; a failed request answers with a status only
// one request in flight at a time; req_stall holds until the response is taken
// reset: built flag cleared, registers to 32, then the grid is zeroed cell by
// cell with req_stall held high
// ---------------------------------------------------------------------------
// rect_update_prefix_sum_query
// 2d difference grid with in-place prefix build and rectangle sum queries
// ---------------------------------------------------------------------------
module rect_update_prefix_sum_query
   import rups_pkg::*;
#(
   parameter int MAX_ROWS = DefMaxRows,
   parameter int MAX_COLS = DefMaxCols
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_opcode,
   input  wire logic [4:0]          req_row_first,
   input  wire logic [4:0]          req_col_first,
   input  wire logic [4:0]          req_row_last,
   input  wire logic [4:0]          req_col_last,
   input  wire logic signed [31:0]  req_amount,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [63:0]       rsp_rect_sum,
   input  wire logic                csr_write,
   input  wire logic                csr_index,
   input  wire logic [5:0]          csr_data
);
   logic [5:0] rows_ff, cols_ff;
   logic [31:0] amt_ff;
   logic [63:0] acc;
   logic is_sum;
   cmd_type cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 6'd32;
         cols_ff <= 6'd32;
      end else if (csr_write) begin
         if (csr_index == CSR_ROWS) rows_ff <= csr_data;
         else cols_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) amt_ff <= req_amount;
   end

   rups_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_row_first,
      .req_col_first, .req_row_last, .req_col_last,
      .rows_cfg(rows_ff), .cols_cfg(cols_ff),
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_is_sum(is_sum), .cmd
   );

   rups_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
      .clock, .cmd, .amount(amt_ff), .acc
   );

   assign rsp_rect_sum = is_sum ? acc : 64'sd0;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while response pending");
   a_nonzero_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_rect_sum == 64'sd0)
      else $error("sum on failed item");
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("no busy after accept");
endmodule
`default_nettype wire
